/* rtl/core/ppsu_pkg.sv */
// ----------------------------------------------------------------------------
// ppsu_pkg
// Types and constants shared by the priority scheduler unit and its checker.
// ----------------------------------------------------------------------------
package ppsu_pkg;

  localparam int CfgW     = 4;
  localparam int SlotW    = 3;
  localparam int ArrivalW = 16;
  localparam int BurstW   = 16;
  localparam int PrioW    = 8;
  localparam int WaitW    = 16;

  localparam logic [CfgW-1:0]  CfgReset = 4'd8;
  localparam logic [WaitW-1:0] WaitMax  = 16'hFFFF;

  localparam logic FuncLoad = 1'b0;
  localparam logic FuncTick = 1'b1;

  typedef struct packed {
    logic [ArrivalW-1:0] arrive;
    logic [BurstW-1:0]   remaining;
    logic [PrioW-1:0]    prio;
    logic [WaitW-1:0]    waited;
  } slot_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHARGE,
    ST_FIN
  } state_e;

endpackage

/* rtl/core/ppsu_ram.sv */
// ----------------------------------------------------------------------------
// ppsu_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ppsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/preemptive_priority_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit
// Preemptive priority scheduler over a table of process slots.
// ----------------------------------------------------------------------------
// A load word writes one slot (arrival tick, burst, priority) and passes to
// FIN; there its result word is loaded into the output register, and the unit
// returns to IDLE to take the next word. A tick word runs the SCAN state and
// then the CHARGE state (CHARGE ends at once when no slot is ready) over the
// n slots in use: the slot table sits in one RAM with a single read port,
// read once to admit arrived slots and pick the highest priority, and once
// more to charge service and waits; each pass reads the n slots and then
// drains the read pipeline. Output stalls hold a finished word in FIN. Ready
// and work-left flags per slot live in flops, so the RAM needs no clearing
// pass after reset. One word is processed at a time; a finished result
// waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit #(
  parameter int SLOTS     = 8,
  parameter int TIME_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ppsu_pkg::CfgW-1:0]   cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [ppsu_pkg::SlotW-1:0]  slot_i,
  input  logic [ppsu_pkg::ArrivalW-1:0] arrival_i,
  input  logic [ppsu_pkg::BurstW-1:0] burst_i,
  input  logic [ppsu_pkg::PrioW-1:0]  priority_req_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        running_valid_o,
  output logic [ppsu_pkg::SlotW-1:0]  running_slot_o,
  output logic                        finished_o,
  output logic [ppsu_pkg::WaitW-1:0]  finished_wait_o,
  output logic                        all_done_o
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NW = ($clog2(SLOTS + 1) > ppsu_pkg::CfgW) ? $clog2(SLOTS + 1)
                                                            : ppsu_pkg::CfgW;
  localparam int CW = (TIME_BITS > ppsu_pkg::ArrivalW) ? TIME_BITS : ppsu_pkg::ArrivalW;
  localparam int EW = $bits(ppsu_pkg::slot_entry_t);

  ppsu_pkg::state_e state_q, state_d;

  logic [ppsu_pkg::CfgW-1:0]  cfg_q;
  logic [NW-1:0]              n_q, n_d;
  logic [NW-1:0]              idx_q, idx_d;
  logic                       rd_pend_q, rd_pend_d;
  logic [SW-1:0]              rd_idx_q, rd_idx_d;
  logic [TIME_BITS-1:0]       now_q, now_d;
  logic [SW-1:0]              cur_q, cur_d;
  logic                       cur_v_q, cur_v_d;
  logic [SLOTS-1:0]           ready_q, ready_d;
  logic [SLOTS-1:0]           live_q, live_d;
  logic                       best_v_q, best_v_d;
  logic [SW-1:0]              best_idx_q, best_idx_d;
  logic [ppsu_pkg::PrioW-1:0] best_prio_q, best_prio_d;

  logic                       res_run_q, res_run_d;
  logic [ppsu_pkg::SlotW-1:0] res_slot_q, res_slot_d;
  logic                       res_fin_q, res_fin_d;
  logic [ppsu_pkg::WaitW-1:0] res_wait_q, res_wait_d;

  logic                       out_valid_q, out_valid_d;
  logic                       out_run_q, out_run_d;
  logic [ppsu_pkg::SlotW-1:0] out_slot_q, out_slot_d;
  logic                       out_fin_q, out_fin_d;
  logic [ppsu_pkg::WaitW-1:0] out_wait_q, out_wait_d;
  logic                       out_done_q, out_done_d;

  logic                       ram_we;
  logic [SW-1:0]              ram_waddr;
  ppsu_pkg::slot_entry_t      ram_wdata;
  logic                       ram_re;
  logic [SW-1:0]              ram_raddr;
  ppsu_pkg::slot_entry_t      ram_rdata;
  logic [EW-1:0]              ram_rdata_raw;

  logic [NW-1:0]              cfg_ext;
  logic [NW-1:0]              n_eff;
  logic [NW-1:0]              slot_ext;
  logic                       slot_ok;
  logic [SW-1:0]              slot_idx;
  logic [SLOTS-1:0]           use_mask;
  logic                       scan_done;
  logic                       charge_done;
  logic                       out_free;
  logic                       admit;
  logic                       rdy;
  logic [ppsu_pkg::BurstW-1:0] rem_new;
  logic [NW-1:0]              best_ext;

  assign cfg_ext  = NW'(cfg_q);
  assign n_eff    = (cfg_q == '0) ? NW'(1)
                  : ((cfg_ext > NW'(SLOTS)) ? NW'(SLOTS) : cfg_ext);
  assign slot_ext = NW'(slot_i);
  assign slot_ok  = slot_ext < NW'(SLOTS);
  assign slot_idx = slot_ext[SW-1:0];
  assign best_ext = NW'(best_idx_q);

  assign scan_done   = (idx_q == n_q) && !rd_pend_q;
  assign charge_done = !best_v_q || scan_done;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != ppsu_pkg::ST_IDLE);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      use_mask[i] = NW'(i) < n_q;
    end
  end

  ppsu_ram #(
    .WIDTH(EW),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata_raw)
  );

  assign ram_rdata = ppsu_pkg::slot_entry_t'(ram_rdata_raw);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ppsu_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (func_i == ppsu_pkg::FuncLoad) ? ppsu_pkg::ST_FIN : ppsu_pkg::ST_SCAN;
        end
      end
      ppsu_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = ppsu_pkg::ST_CHARGE;
        end
      end
      ppsu_pkg::ST_CHARGE: begin
        if (charge_done) begin
          state_d = ppsu_pkg::ST_FIN;
        end
      end
      ppsu_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = ppsu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ppsu_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    n_d         = n_q;
    idx_d       = idx_q;
    rd_pend_d   = 1'b0;
    rd_idx_d    = idx_q[SW-1:0];
    now_d       = now_q;
    cur_d       = cur_q;
    cur_v_d     = cur_v_q;
    ready_d     = ready_q;
    live_d      = live_q;
    best_v_d    = best_v_q;
    best_idx_d  = best_idx_q;
    best_prio_d = best_prio_q;
    res_run_d   = res_run_q;
    res_slot_d  = res_slot_q;
    res_fin_d   = res_fin_q;
    res_wait_d  = res_wait_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_run_d   = out_run_q;
    out_slot_d  = out_slot_q;
    out_fin_d   = out_fin_q;
    out_wait_d  = out_wait_q;
    out_done_d  = out_done_q;
    ram_we      = 1'b0;
    ram_waddr   = rd_idx_q;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = idx_q[SW-1:0];
    admit       = 1'b0;
    rdy         = 1'b0;
    rem_new     = ram_rdata.remaining - 1'b1;

    case (state_q)
      ppsu_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          n_d        = n_eff;
          idx_d      = '0;
          best_v_d   = 1'b0;
          res_run_d  = 1'b0;
          res_slot_d = '0;
          res_fin_d  = 1'b0;
          res_wait_d = '0;
          if (func_i == ppsu_pkg::FuncLoad && slot_ok) begin
            ram_we              = 1'b1;
            ram_waddr           = slot_idx;
            ram_wdata.arrive    = arrival_i;
            ram_wdata.remaining = burst_i;
            ram_wdata.prio      = priority_req_i;
            ram_wdata.waited    = '0;
            live_d[slot_idx]    = (burst_i != '0);
            ready_d[slot_idx]   = 1'b0;
            if (cur_v_q && cur_q == slot_idx) begin
              cur_v_d = 1'b0;
            end
          end
        end
      end

      ppsu_pkg::ST_SCAN: begin
        if (idx_q < n_q) begin
          ram_re    = 1'b1;
          rd_pend_d = 1'b1;
          idx_d     = idx_q + 1'b1;
        end
        if (rd_pend_q) begin
          admit = live_q[rd_idx_q] && (CW'(ram_rdata.arrive) <= CW'(now_q));
          rdy   = ready_q[rd_idx_q] || admit;
          ready_d[rd_idx_q] = rdy;
          if (rdy && (!best_v_q || ram_rdata.prio > best_prio_q ||
                      (ram_rdata.prio == best_prio_q && cur_v_q && cur_q == rd_idx_q))) begin
            best_v_d    = 1'b1;
            best_idx_d  = rd_idx_q;
            best_prio_d = ram_rdata.prio;
          end
        end
        if (scan_done) begin
          idx_d = '0;
          now_d = (now_q == '1) ? now_q : now_q + 1'b1;
        end
      end

      ppsu_pkg::ST_CHARGE: begin
        if (best_v_q && idx_q < n_q) begin
          ram_re    = 1'b1;
          rd_pend_d = 1'b1;
          idx_d     = idx_q + 1'b1;
        end
        if (rd_pend_q) begin
          if (rd_idx_q == best_idx_q) begin
            ram_we              = 1'b1;
            ram_wdata.remaining = rem_new;
            res_run_d           = 1'b1;
            res_slot_d          = best_ext[ppsu_pkg::SlotW-1:0];
            if (rem_new == '0) begin
              res_fin_d         = 1'b1;
              res_wait_d        = ram_rdata.waited;
              ready_d[rd_idx_q] = 1'b0;
              live_d[rd_idx_q]  = 1'b0;
              cur_v_d           = 1'b0;
            end else begin
              cur_d   = best_idx_q;
              cur_v_d = 1'b1;
            end
          end else if (ready_q[rd_idx_q]) begin
            ram_we           = 1'b1;
            ram_wdata.waited = (ram_rdata.waited == ppsu_pkg::WaitMax)
                             ? ram_rdata.waited : ram_rdata.waited + 1'b1;
          end
        end
        if (!best_v_q) begin
          cur_v_d = 1'b0;
        end
      end

      ppsu_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_run_d   = res_run_q;
          out_slot_d  = res_slot_q;
          out_fin_d   = res_fin_q;
          out_wait_d  = res_wait_q;
          out_done_d  = ~|(live_q & use_mask);
        end
      end

      default: begin
        idx_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ppsu_pkg::ST_IDLE;
      cfg_q       <= ppsu_pkg::CfgReset;
      n_q         <= '0;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      now_q       <= '0;
      cur_q       <= '0;
      cur_v_q     <= 1'b0;
      ready_q     <= '0;
      live_q      <= '0;
      best_v_q    <= 1'b0;
      best_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      n_q         <= n_d;
      idx_q       <= idx_d;
      rd_pend_q   <= rd_pend_d;
      now_q       <= now_d;
      cur_q       <= cur_d;
      cur_v_q     <= cur_v_d;
      ready_q     <= ready_d;
      live_q      <= live_d;
      best_v_q    <= best_v_d;
      best_idx_q  <= best_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    best_prio_q <= best_prio_d;
    res_run_q   <= res_run_d;
    res_slot_q  <= res_slot_d;
    res_fin_q   <= res_fin_d;
    res_wait_q  <= res_wait_d;
    out_run_q   <= out_run_d;
    out_slot_q  <= out_slot_d;
    out_fin_q   <= out_fin_d;
    out_wait_q  <= out_wait_d;
    out_done_q  <= out_done_d;
  end

  assign out_valid_o     = out_valid_q;
  assign running_valid_o = out_run_q;
  assign running_slot_o  = out_slot_q;
  assign finished_o      = out_fin_q;
  assign finished_wait_o = out_wait_q;
  assign all_done_o      = out_done_q;

endmodule

/* rtl/core/ppsu_checker.sv */
// ----------------------------------------------------------------------------
// ppsu_checker
// Port-level checks on the priority scheduler unit, bound to the top level.
// ----------------------------------------------------------------------------
module ppsu_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       running_valid_o,
  input logic [ppsu_pkg::SlotW-1:0] running_slot_o,
  input logic                       finished_o,
  input logic [ppsu_pkg::WaitW-1:0] finished_wait_o,
  input logic                       all_done_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(running_valid_o) &&
      $stable(running_slot_o) && $stable(finished_o) && $stable(finished_wait_o) &&
      $stable(all_done_o)))
    else $error("output word changed while stalled");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !running_valid_o) |-> (running_slot_o == '0 && !finished_o))
    else $error("idle or load word reports a running slot");

  a_wait_only_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !finished_o) |-> (finished_wait_o == '0))
    else $error("wait reported without completion");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again before the word was processed");

endmodule

bind preemptive_priority_scheduler_unit ppsu_checker u_ppsu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .running_valid_o(running_valid_o),
  .running_slot_o (running_slot_o),
  .finished_o     (finished_o),
  .finished_wait_o(finished_wait_o),
  .all_done_o     (all_done_o)
);
